// ===== rtl/cardinal_spline_eval_core_assert.svh =====
// Assertion macros for the cardinal spline evaluator.
`ifndef CARDINAL_SPLINE_EVAL_CORE_ASSERT_SVH
`define CARDINAL_SPLINE_EVAL_CORE_ASSERT_SVH

`ifndef SYNTH
// Check a property on the rising clock, masked while reset is low.
`define CSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("cardinal spline core: check failed");
// Check a property on the rising clock, also during reset.
`define CSP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cardinal spline core: check failed");
`else
`define CSP_ASSERT(lbl, clk, rst_n, prop)
`define CSP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/csp_pkg.sv =====
// Types, constants and rounding helper shared by the cardinal spline evaluator.
package csp_pkg;

    localparam int unsigned T_W    = 17;
    localparam int unsigned S_W    = 18;
    localparam int unsigned P_W    = 32;
    localparam int unsigned COEF_W = 20;
    localparam int unsigned WGT_W  = 21;
    localparam int unsigned PROD_W = 37;
    localparam int unsigned SUM_W  = 39;

    localparam logic [T_W-1:0] T_MAX = 17'd65536;
    localparam logic [S_W-1:0] S_MAX = 18'd131072;

    localparam logic signed [COEF_W-1:0] ONE_Q16   = 20'sd65536;
    localparam logic signed [COEF_W-1:0] TWO_Q16   = 20'sd131072;
    localparam logic signed [COEF_W-1:0] THREE_Q16 = 20'sd196608;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 39'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -39'sd2147483648;

    typedef logic signed [P_W-1:0]    t_point;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [WGT_W-1:0]  t_wgt;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_point a;
        t_point b;
        t_point c;
        t_point d;
    } t_points;

    typedef struct packed {
        t_wgt w0;
        t_wgt w1;
        t_wgt w2;
        t_wgt w3;
    } t_weights;

    typedef struct packed {
        logic [3:0] ld_wgt;
        logic [1:0] ld_mix;
    } t_pipe_ctrl;

    // Round a Q.32 product to Q.16, ties toward plus infinity.
    function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] prod);
        logic signed [63:0] r;
        r = (prod + 64'sd32768) >>> 16;
        return r[47:0];
    endfunction

endpackage

// ===== rtl/cardinal_spline_eval_core.sv =====
// Top level of the cardinal spline evaluator: stream ports and pipeline control.
//
//   channel   dir   beat contents
//   s_axis    in    p0..p3, t, tension (one axis of one segment point)
//   m_axis    out   interpolated value, saturation flag
//
// Six register stages lie between the input beat and the output beat.
// One beat per cycle sustained while m_axis_tready stays high; the chain of dependent products sets the depth:
// t^2, t^3, the weight terms, then the point products and the final sum.
// Each stage holds a valid bit and loads when it is empty or drains downstream,
// so bubbles close up under stall and nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits only.
`include "cardinal_spline_eval_core_assert.svh"

module cardinal_spline_eval_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_a[31:0], point_b[63:32], point_c[95:64], point_d[127:96],
    // param_t[144:128], tension[162:145], zero pad [167:163]
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // value[31:0], saturated[32], zero pad [39:33]
    output logic [39:0]  m_axis_tdata
);

    localparam int unsigned STAGES = 6;

    logic [STAGES-1:0]    r_vld;
    logic [STAGES:0]      adv;
    csp_pkg::t_pipe_ctrl  ctrl;
    csp_pkg::t_points     in_pts;
    csp_pkg::t_points     r_pt_dly [4];
    csp_pkg::t_weights    weights;
    csp_pkg::t_point      value;
    logic                 saturated;

    always_comb begin
        adv[STAGES] = m_axis_tready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign ctrl.ld_wgt = adv[3:0];
    assign ctrl.ld_mix = adv[5:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= (k == 0) ? s_axis_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign in_pts.a = s_axis_tdata[31:0];
    assign in_pts.b = s_axis_tdata[63:32];
    assign in_pts.c = s_axis_tdata[95:64];
    assign in_pts.d = s_axis_tdata[127:96];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (adv[k]) begin
                r_pt_dly[k] <= (k == 0) ? in_pts : r_pt_dly[(k == 0) ? 0 : k-1];
            end
        end
    end

    csp_weight u_weight (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_param_t (s_axis_tdata[144:128]),
        .i_tension (s_axis_tdata[162:145]),
        .o_weights (weights)
    );

    csp_blend u_blend (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_weights   (weights),
        .i_points    (r_pt_dly[3]),
        .o_value     (value),
        .o_saturated (saturated)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = r_vld[STAGES-1];
    assign m_axis_tdata  = {7'b0, saturated, value};

    `CSP_ASSERT(a_sat_at_limit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[32] |-> (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000))
    `CSP_ASSERT(a_accept_fills_first, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> r_vld[0])
    `CSP_ASSERT_ALWAYS(a_full_stall_blocks, i_clk, s_axis_tready |-> (!(&r_vld) || m_axis_tready))

endmodule

// ===== rtl/csp_weight.sv =====
// Four-stage pipeline forming t^2, t^3 and the four cardinal spline weights.
module csp_weight (
    input  logic                          i_clk,
    input  csp_pkg::t_pipe_ctrl           i_ctrl,
    input  logic [csp_pkg::T_W-1:0]       i_param_t,
    input  logic [csp_pkg::S_W-1:0]       i_tension,
    output csp_pkg::t_weights             o_weights
);

    logic [csp_pkg::T_W-1:0] n1_t;
    logic [csp_pkg::S_W-1:0] n1_s;
    logic [33:0]             n1_tt;
    logic [csp_pkg::T_W-1:0] r1_t, r1_t2;
    logic [csp_pkg::S_W-1:0] r1_s;

    logic [33:0]             n2_t3m;
    logic [34:0]             n2_stm;
    csp_pkg::t_coef          n2_s;
    logic [csp_pkg::T_W-1:0] r2_t, r2_t2, r2_t3;
    logic [csp_pkg::S_W-1:0] r2_st;
    logic [csp_pkg::S_W-1:0] r2_s;
    csp_pkg::t_coef          r2_ca, r2_cb, r2_cc, r2_cd;

    csp_pkg::t_coef          n3_t, n3_t2, n3_t3, n3_s, n3_dw0, n3_dw3;
    logic signed [39:0]      n3_m0, n3_ma, n3_mb, n3_mc, n3_md, n3_m3;
    csp_pkg::t_wgt           r3_p0, r3_pa, r3_pb, r3_pc, r3_pd, r3_p3, r3_st;

    csp_pkg::t_weights       r4_w;

    always_comb begin
        n1_t  = (i_param_t > csp_pkg::T_MAX) ? csp_pkg::T_MAX : i_param_t;
        n1_s  = (i_tension > csp_pkg::S_MAX) ? csp_pkg::S_MAX : i_tension;
        n1_tt = n1_t * n1_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_wgt[0]) begin
            r1_t  <= n1_t;
            r1_s  <= n1_s;
            r1_t2 <= 17'((n1_tt + 34'd32768) >> 16);
        end
    end

    always_comb begin
        n2_t3m = r1_t2 * r1_t;
        n2_stm = r1_s * r1_t;
        n2_s   = csp_pkg::t_coef'({2'b00, r1_s});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_wgt[1]) begin
            r2_t  <= r1_t;
            r2_t2 <= r1_t2;
            r2_t3 <= 17'((n2_t3m + 34'd32768) >> 16);
            r2_st <= 18'((n2_stm + 35'd32768) >> 16);
            r2_s  <= r1_s;
            r2_ca <= csp_pkg::TWO_Q16 - n2_s;
            r2_cb <= n2_s - csp_pkg::THREE_Q16;
            r2_cc <= n2_s - csp_pkg::TWO_Q16;
            r2_cd <= csp_pkg::THREE_Q16 - (n2_s <<< 1);
        end
    end

    always_comb begin
        n3_t   = csp_pkg::t_coef'({3'b000, r2_t});
        n3_t2  = csp_pkg::t_coef'({3'b000, r2_t2});
        n3_t3  = csp_pkg::t_coef'({3'b000, r2_t3});
        n3_s   = csp_pkg::t_coef'({2'b00, r2_s});
        n3_dw0 = (n3_t2 <<< 1) - n3_t - n3_t3;
        n3_dw3 = n3_t3 - n3_t2;
        n3_m0  = n3_s * n3_dw0;
        n3_ma  = r2_ca * n3_t3;
        n3_mb  = r2_cb * n3_t2;
        n3_mc  = r2_cc * n3_t3;
        n3_md  = r2_cd * n3_t2;
        n3_m3  = n3_s * n3_dw3;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_wgt[2]) begin
            r3_p0 <= csp_pkg::t_wgt'(csp_pkg::rnd_q16(64'(n3_m0)));
            r3_pa <= csp_pkg::t_wgt'(csp_pkg::rnd_q16(64'(n3_ma)));
            r3_pb <= csp_pkg::t_wgt'(csp_pkg::rnd_q16(64'(n3_mb)));
            r3_pc <= csp_pkg::t_wgt'(csp_pkg::rnd_q16(64'(n3_mc)));
            r3_pd <= csp_pkg::t_wgt'(csp_pkg::rnd_q16(64'(n3_md)));
            r3_p3 <= csp_pkg::t_wgt'(csp_pkg::rnd_q16(64'(n3_m3)));
            r3_st <= csp_pkg::t_wgt'({3'b000, r2_st});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_wgt[3]) begin
            r4_w.w0 <= r3_p0;
            r4_w.w1 <= r3_pa + r3_pb + csp_pkg::t_wgt'(csp_pkg::ONE_Q16);
            r4_w.w2 <= r3_pc + r3_pd + r3_st;
            r4_w.w3 <= r3_p3;
        end
    end

    assign o_weights = r4_w;

endmodule

// ===== rtl/csp_blend.sv =====
// Two-stage weighted sum of the control values with rounding and saturation.
module csp_blend (
    input  logic                      i_clk,
    input  csp_pkg::t_pipe_ctrl       i_ctrl,
    input  csp_pkg::t_weights         i_weights,
    input  csp_pkg::t_points          i_points,
    output csp_pkg::t_point           o_value,
    output logic                      o_saturated
);

    csp_pkg::t_wgt       w [4];
    csp_pkg::t_point     p [4];
    logic signed [52:0]  n5_m [4];
    csp_pkg::t_prod      r5_prod [4];

    logic signed [csp_pkg::SUM_W-1:0] n6_sum;
    csp_pkg::t_point                  r6_value;
    logic                             r6_sat;

    always_comb begin
        w[0] = i_weights.w0;
        w[1] = i_weights.w1;
        w[2] = i_weights.w2;
        w[3] = i_weights.w3;
        p[0] = i_points.a;
        p[1] = i_points.b;
        p[2] = i_points.c;
        p[3] = i_points.d;
        for (int k = 0; k < 4; k++) begin
            n5_m[k] = w[k] * p[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_mix[0]) begin
            for (int k = 0; k < 4; k++) begin
                r5_prod[k] <= csp_pkg::t_prod'(csp_pkg::rnd_q16(64'(n5_m[k])));
            end
        end
    end

    always_comb begin
        n6_sum = csp_pkg::SUM_W'(r5_prod[0]) + csp_pkg::SUM_W'(r5_prod[1])
               + csp_pkg::SUM_W'(r5_prod[2]) + csp_pkg::SUM_W'(r5_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_mix[1]) begin
            priority if (n6_sum > csp_pkg::SUM_MAX) begin
                r6_value <= csp_pkg::t_point'(csp_pkg::SUM_MAX);
                r6_sat   <= 1'b1;
            end else if (n6_sum < csp_pkg::SUM_MIN) begin
                r6_value <= csp_pkg::t_point'(csp_pkg::SUM_MIN);
                r6_sat   <= 1'b1;
            end else begin
                r6_value <= csp_pkg::t_point'(n6_sum);
                r6_sat   <= 1'b0;
            end
        end
    end

    assign o_value     = r6_value;
    assign o_saturated = r6_sat;

endmodule

// ===== tb/sv/cardinal_spline_eval_core_tb.sv =====
// Self-checking testbench for the cardinal spline evaluator stream core.
`timescale 1ns / 100ps

module cardinal_spline_eval_core_tb;

    typedef struct {
        logic signed [31:0] value;
        logic               saturated;
    } t_axis_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // point_a, point_b, point_c, point_d, param_t, tension, zero pad
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    // value, saturated, zero pad
    logic [39:0]  m_axis_tdata;

    t_axis_result expected_axis_q[$];
    int           mismatch_count = 0;
    logic         traffic_gaps_on = 1'b0;
    int           sink_stall_left = 0;

    localparam csp_pkg::t_point P_MAX = 32'sh7FFF_FFFF;
    localparam csp_pkg::t_point P_MIN = 32'sh8000_0000;
    localparam logic [csp_pkg::T_W-1:0] T_HALF = 17'd32768;
    localparam logic [csp_pkg::S_W-1:0] S_CATMULL = 18'd32768;

    cardinal_spline_eval_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint round_q16(input longint x, input longint y);
        return (x * y + 64'sd32768) >>> 16;
    endfunction

    function automatic t_axis_result predict_axis_value(
        input csp_pkg::t_point pa, input csp_pkg::t_point pb,
        input csp_pkg::t_point pc, input csp_pkg::t_point pd,
        input logic [csp_pkg::T_W-1:0] t_in, input logic [csp_pkg::S_W-1:0] s_in);
        longint one, t, s, t2, t3, w0, w1, w2, w3, sum;
        t_axis_result r;
        one = longint'(csp_pkg::ONE_Q16);
        t = (t_in > csp_pkg::T_MAX) ? longint'(csp_pkg::T_MAX) : longint'(t_in);
        s = (s_in > csp_pkg::S_MAX) ? longint'(csp_pkg::S_MAX) : longint'(s_in);
        t2 = round_q16(t, t);
        t3 = round_q16(t2, t);
        w0 = round_q16(s, 2 * t2 - t - t3);
        w1 = round_q16(2 * one - s, t3) + round_q16(s - 3 * one, t2) + one;
        w2 = round_q16(s - 2 * one, t3) + round_q16(3 * one - 2 * s, t2) + round_q16(s, t);
        w3 = round_q16(s, t3 - t2);
        sum = round_q16(w0, longint'(pa)) + round_q16(w1, longint'(pb))
            + round_q16(w2, longint'(pc)) + round_q16(w3, longint'(pd));
        r.saturated = 1'b0;
        if (sum > longint'(csp_pkg::SUM_MAX)) begin
            sum = longint'(csp_pkg::SUM_MAX);
            r.saturated = 1'b1;
        end else if (sum < longint'(csp_pkg::SUM_MIN)) begin
            sum = longint'(csp_pkg::SUM_MIN);
            r.saturated = 1'b1;
        end
        r.value = sum[31:0];
        return r;
    endfunction

    task automatic send_segment(input csp_pkg::t_point pa, input csp_pkg::t_point pb,
                                input csp_pkg::t_point pc, input csp_pkg::t_point pd,
                                input logic [csp_pkg::T_W-1:0] t_in,
                                input logic [csp_pkg::S_W-1:0] s_in);
        if (traffic_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, s_in, t_in, pd, pc, pb, pa};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_axis_q.push_back(predict_axis_value(pa, pb, pc, pd, t_in, s_in));
    endtask

    function automatic csp_pkg::t_point rand_point();
        return csp_pkg::t_point'($urandom);
    endfunction

    function automatic csp_pkg::t_point rand_small_point();
        return csp_pkg::t_point'($urandom_range(0, 32'h0020_0000))
             - csp_pkg::t_point'(32'h0010_0000);
    endfunction

    // Hold tready low in random bursts.
    always @(posedge i_clk) begin
        if (sink_stall_left > 0) begin
            m_axis_tready   <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end else if (traffic_gaps_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready   <= 1'b0;
            sink_stall_left <= $urandom_range(1, 6) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_axis_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_axis_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual value %h sat %b",
                         $time, m_axis_tdata[31:0], m_axis_tdata[32]);
            end else begin
                want = expected_axis_q.pop_front();
                if (m_axis_tdata[31:0] !== want.value) begin
                    mismatch_count++;
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, want.value, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[32] !== want.saturated) begin
                    mismatch_count++;
                    $display("%0t: saturated mismatch, expected %b, actual %b",
                             $time, want.saturated, m_axis_tdata[32]);
                end
            end
        end
    end

    task automatic test_corner_values();
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(P_MAX, P_MAX, P_MAX, P_MAX, 0, csp_pkg::S_MAX);
        send_segment(P_MIN, P_MIN, P_MIN, P_MIN, csp_pkg::T_MAX, 0);
        send_segment(P_MIN, P_MAX, P_MIN, P_MAX, T_HALF, S_CATMULL);
        send_segment(P_MAX, P_MIN, P_MAX, P_MIN, T_HALF, 0);
        send_segment(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                     T_HALF, S_CATMULL);
        send_segment(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                     csp_pkg::T_MAX, csp_pkg::S_MAX);
        send_segment(-32'sh0005_0000, 32'sh0000_8000, 32'sh0007_0000, -32'sh0001_0000,
                     17'd1, 18'd1);
        send_segment(32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0, 32'sh0000_0001,
                     17'd65535, 18'd131071);
        send_segment(32'sh0000_FFFF, 32'sh7FFF_0000, -32'sh7FFF_0000, 32'sh0, 17'd49152,
                     S_CATMULL);
    endtask

    task automatic test_clamping();
        send_segment(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                     17'd65537, S_CATMULL);
        send_segment(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                     17'h1FFFF, S_CATMULL);
        send_segment(-32'sh0003_0000, 32'sh0002_0000, 32'sh0009_0000, 32'sh0001_0000,
                     T_HALF, 18'd131073);
        send_segment(-32'sh0003_0000, 32'sh0002_0000, 32'sh0009_0000, 32'sh0001_0000,
                     T_HALF, 18'h3FFFF);
        send_segment(P_MAX, P_MIN, P_MAX, P_MIN, 17'h1FFFF, 18'h3FFFF);
    endtask

    task automatic test_saturation();
        send_segment(P_MIN, P_MAX, P_MAX, P_MIN, T_HALF, csp_pkg::S_MAX);
        send_segment(P_MAX, P_MIN, P_MIN, P_MAX, T_HALF, csp_pkg::S_MAX);
        send_segment(P_MIN, P_MAX, P_MAX, P_MIN, 17'd16384, 18'h3FFFF);
        send_segment(P_MAX, P_MIN, P_MIN, P_MAX, 17'd49152, csp_pkg::S_MAX);
    endtask

    task automatic test_catmull_rom_random();
        logic [csp_pkg::S_W-1:0] s;
        for (int i = 0; i < 250; i++) begin
            s = ($urandom_range(0, 1) == 0) ? S_CATMULL
                                            : 18'($urandom_range(0, csp_pkg::S_MAX));
            send_segment(rand_small_point(), rand_small_point(), rand_small_point(),
                         rand_small_point(), 17'($urandom_range(0, csp_pkg::T_MAX)), s);
        end
    endtask

    task automatic test_full_range_random();
        logic [csp_pkg::T_W-1:0] t;
        logic [csp_pkg::S_W-1:0] s;
        for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                t = 17'($urandom_range(0, 2**csp_pkg::T_W - 1));
                s = 18'($urandom_range(0, 2**csp_pkg::S_W - 1));
            end else begin
                t = 17'($urandom_range(0, csp_pkg::T_MAX));
                s = 18'($urandom_range(0, csp_pkg::S_MAX));
            end
            send_segment(rand_point(), rand_point(), rand_point(), rand_point(), t, s);
        end
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_segment(rand_point(), rand_small_point(), rand_small_point(), rand_point(),
                         17'($urandom_range(0, csp_pkg::T_MAX)),
                         18'($urandom_range(0, csp_pkg::S_MAX)));
        s_axis_tvalid <= 1'b0;
        while (expected_axis_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 20; i++)
            send_segment(rand_point(), rand_small_point(), rand_small_point(), rand_point(),
                         17'($urandom_range(0, csp_pkg::T_MAX)),
                         18'($urandom_range(0, csp_pkg::S_MAX)));
    endtask

    task automatic test_back_to_back();
        traffic_gaps_on <= 1'b0;
        for (int i = 0; i < 80; i++)
            send_segment(rand_point(), rand_point(), rand_small_point(), rand_small_point(),
                         17'($urandom_range(0, 2**csp_pkg::T_W - 1)),
                         18'($urandom_range(0, 2**csp_pkg::S_W - 1)));
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_axis_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_axis_q.size() != 0) begin
            mismatch_count += expected_axis_q.size();
            $display("%0t: %0d beats expected, none arrived", $time, expected_axis_q.size());
        end
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        traffic_gaps_on <= 1'b1;
        @(posedge i_clk);
        test_corner_values();
        test_clamping();
        test_saturation();
        test_catmull_rom_random();
        test_full_range_random();
        test_drain_pause();
        test_back_to_back();
        finish_run();
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
